[hw/rtl/generational_handle_allocator_macros.svh]
// ----------------------------------------------------------------------------
// Generational handle allocator assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
`define GHA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("gha: assertion failed");
`define GHA_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("gha: assertion failed");
`else
`define GHA_ASSERT(lbl, clk, rst, prop)
`define GHA_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif

`endif

[hw/rtl/gha_pkg.sv]
// ----------------------------------------------------------------------------
// gha_pkg
// Types, codes and sizes shared by the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

   localparam int SLOT_COUNT = 1024;
   localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
   localparam int COUNT_BITS = $clog2(SLOT_COUNT + 1);
   localparam int INDEX_BITS = 20;
   localparam int GEN_BITS   = 32 - INDEX_BITS;
   localparam logic [GEN_BITS-1:0] MAX_GEN = {GEN_BITS{1'b1}};

   localparam logic [1:0] CMD_CREATE  = 2'd0;
   localparam logic [1:0] CMD_LOOKUP  = 2'd1;
   localparam logic [1:0] CMD_RELEASE = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] handle_in;
      logic [31:0] payload_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] handle_out;
      logic [31:0] payload_out;
   } rsp_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_POP,
      STATE_EXEC
   } state_type;

   typedef struct packed {
      logic load;
      logic pop;
      logic exec;
   } ctl_cmd_type;

   typedef struct packed {
      logic pop_sel;
      logic rsp_busy;
   } ctl_stat_type;

endpackage

[hw/rtl/gha_datapath.sv]
// ----------------------------------------------------------------------------
// gha_datapath
// Slot table, payload store, free stack, counters and response register.
// ----------------------------------------------------------------------------
`include "generational_handle_allocator_macros.svh"

module gha_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  gha_pkg::req_type      req_data,
   input  gha_pkg::ctl_cmd_type  ctl,
   output gha_pkg::ctl_stat_type stat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output gha_pkg::rsp_type      rsp_data
);
   import gha_pkg::*;

   logic [GEN_BITS:0]   slot_mem  [SLOT_COUNT];
   logic [31:0]         pay_mem   [SLOT_COUNT];
   logic [SLOT_BITS-1:0] stack_mem [SLOT_COUNT];

   logic [1:0]            cmd_ff, cmd_in;
   logic [31:0]           handle_ff, handle_in;
   logic [31:0]           payload_ff, payload_in;
   logic                  pop_ff, pop_in;
   logic [SLOT_BITS-1:0]  slot_ff, slot_in;
   logic [COUNT_BITS-1:0] used_count_ff, used_count_in;
   logic [COUNT_BITS-1:0] free_count_ff, free_count_in;
   logic [GEN_BITS:0]     slot_rd_ff;
   logic [31:0]           pay_rd_ff;
   logic [SLOT_BITS-1:0]  stack_rd_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [INDEX_BITS-1:0] req_field;
   logic [SLOT_BITS-1:0]  req_slot;
   logic                  slot_re;
   logic [SLOT_BITS-1:0]  slot_ra;
   logic                  stack_re;
   logic [SLOT_BITS-1:0]  stack_ra;

   logic [INDEX_BITS-1:0] h_field;
   logic [GEN_BITS-1:0]   h_gen;
   logic [GEN_BITS-1:0]   cur_gen;
   logic                  handle_ok;
   logic                  create_ok;
   logic [GEN_BITS-1:0]   new_gen;
   logic                  push_ok;
   logic                  slot_we;
   logic [GEN_BITS:0]     slot_wd;
   logic                  pay_we;
   logic                  stack_we;

   assign req_field = req_data.handle_in[INDEX_BITS-1:0];
   assign req_slot  = SLOT_BITS'(req_field - INDEX_BITS'(1));

   assign stat.pop_sel  = (req_data.cmd == CMD_CREATE) && (free_count_ff != '0);
   assign stat.rsp_busy = rsp_valid_ff && !rsp_ready;

   assign stack_re = ctl.load && stat.pop_sel;
   assign stack_ra = SLOT_BITS'(free_count_ff - COUNT_BITS'(1));
   assign slot_re  = (ctl.load && !stat.pop_sel) || ctl.pop;
   assign slot_ra  = ctl.pop ? stack_rd_ff : req_slot;

   // item decode
   assign h_field = handle_ff[INDEX_BITS-1:0];
   assign h_gen   = handle_ff[31:INDEX_BITS];
   assign cur_gen = slot_rd_ff[GEN_BITS-1:0];

   assign handle_ok = (h_field != '0) && (h_gen != '0)
                      && (h_field <= INDEX_BITS'(used_count_ff))
                      && slot_rd_ff[GEN_BITS] && (cur_gen == h_gen);
   assign create_ok = pop_ff || (used_count_ff < COUNT_BITS'(SLOT_COUNT));
   assign new_gen   = !pop_ff ? GEN_BITS'(1)
                    : (cur_gen < MAX_GEN) ? cur_gen + GEN_BITS'(1) : cur_gen;
   assign push_ok   = (cur_gen < MAX_GEN) && (free_count_ff < COUNT_BITS'(SLOT_COUNT));

   always_comb begin
      cmd_in        = cmd_ff;
      handle_in     = handle_ff;
      payload_in    = payload_ff;
      pop_in        = pop_ff;
      slot_in       = slot_ff;
      used_count_in = used_count_ff;
      free_count_in = free_count_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      slot_we       = 1'b0;
      slot_wd       = {1'b1, new_gen};
      pay_we        = 1'b0;
      stack_we      = 1'b0;

      if (ctl.load) begin
         cmd_in     = req_data.cmd;
         handle_in  = req_data.handle_in;
         payload_in = req_data.payload_in;
         pop_in     = stat.pop_sel;
         slot_in    = (req_data.cmd == CMD_CREATE) ? used_count_ff[SLOT_BITS-1:0] : req_slot;
      end
      if (ctl.pop) begin
         slot_in = stack_rd_ff;
      end

      if (ctl.exec) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '{status: STATUS_INVALID, handle_out: '0, payload_out: '0};
         case (cmd_ff)
            CMD_CREATE: begin
               if (create_ok) begin
                  slot_we = 1'b1;
                  slot_wd = {1'b1, new_gen};
                  pay_we  = 1'b1;
                  if (pop_ff) begin
                     free_count_in = free_count_ff - COUNT_BITS'(1);
                  end else begin
                     used_count_in = used_count_ff + COUNT_BITS'(1);
                  end
                  rsp_data_in.status     = STATUS_OK;
                  rsp_data_in.handle_out = {new_gen, INDEX_BITS'(slot_ff) + INDEX_BITS'(1)};
               end else begin
                  rsp_data_in.status = STATUS_FULL;
               end
            end
            CMD_LOOKUP: begin
               if (handle_ok) begin
                  rsp_data_in.status      = STATUS_OK;
                  rsp_data_in.payload_out = pay_rd_ff;
               end
            end
            CMD_RELEASE: begin
               if (handle_ok) begin
                  slot_we = 1'b1;
                  slot_wd = {1'b0, cur_gen};
                  if (push_ok) begin
                     stack_we      = 1'b1;
                     free_count_in = free_count_ff + COUNT_BITS'(1);
                  end
                  rsp_data_in.status      = STATUS_OK;
                  rsp_data_in.payload_out = pay_rd_ff;
               end
            end
            default: begin
               rsp_data_in.status = STATUS_INVALID;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_count_ff <= '0;
         free_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         used_count_ff <= used_count_in;
         free_count_ff <= free_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      handle_ff   <= handle_in;
      payload_ff  <= payload_in;
      pop_ff      <= pop_in;
      slot_ff     <= slot_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_ff] <= slot_wd;
      end
      if (pay_we) begin
         pay_mem[slot_ff] <= payload_ff;
      end
      if (slot_re) begin
         slot_rd_ff <= slot_mem[slot_ra];
         pay_rd_ff  <= pay_mem[slot_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[free_count_ff[SLOT_BITS-1:0]] <= slot_ff;
      end
      if (stack_re) begin
         stack_rd_ff <= stack_mem[stack_ra];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `GHA_ASSERT(a_used_bound, clock, reset, used_count_ff <= COUNT_BITS'(SLOT_COUNT))
   `GHA_ASSERT(a_free_bound, clock, reset, free_count_ff <= used_count_ff)
   `GHA_ASSERT(a_exec_slot, clock, reset, !(ctl.exec && stat.rsp_busy))
   `GHA_ASSERT_NEXT(a_exec_rsp, clock, reset, ctl.exec, rsp_valid_ff)

endmodule

[hw/rtl/gha_ctrl.sv]
// ----------------------------------------------------------------------------
// gha_ctrl
// Sequencer: accept, optional free stack pop, execute and respond.
// ----------------------------------------------------------------------------
module gha_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  gha_pkg::ctl_stat_type stat,
   output gha_pkg::ctl_cmd_type  ctl
);
   import gha_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      case (state_ff)
         STATE_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = stat.pop_sel ? STATE_POP : STATE_EXEC;
            end
         end
         STATE_POP: begin
            ctl.pop  = 1'b1;
            state_in = STATE_EXEC;
         end
         STATE_EXEC: begin
            if (!stat.rsp_busy) begin
               ctl.exec = 1'b1;
               state_in = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

endmodule

[hw/rtl/generational_handle_allocator.sv]
// Response: a request is accepted in IDLE with a slot table read, or, for a create
// that reuses a freed slot, with a free stack read and then a slot table read in
// POP; EXEC registers the response once the previous one is taken. A new request
// is accepted only in IDLE once the last has executed (slot table read and write).
// Reset: counters and handshake state clear synchronously; tables keep no reset and
// no clearing pass runs; entries past the fill count may be read but go unused.
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Slot table handing out generation-tagged handles with create, lookup, release.
// ----------------------------------------------------------------------------
module generational_handle_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  gha_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output gha_pkg::rsp_type rsp_data
);
   import gha_pkg::*;

   ctl_cmd_type  ctl;
   ctl_stat_type stat;

   gha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   gha_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctl       (ctl),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
